// ----- rtl/core/pab_pkg.sv -----
`timescale 1ns / 1ps
package pab_pkg;
    localparam int ChanW = 8;

    typedef enum logic [3:0] {
        OP_NEG = 4'd0, OP_COPY = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3, OP_MUL = 4'd4,
        OP_DIV = 4'd5, OP_MIN = 4'd6, OP_MAX = 4'd7, OP_DIFF = 4'd8, OP_BLEND = 4'd9
    } op_t;

    localparam logic [1:0] FMT_BIN  = 2'd0;
    localparam logic [1:0] FMT_GRAY = 2'd1;
    localparam logic [1:0] FMT_565  = 2'd2;
    localparam logic [1:0] FMT_RSVD = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_FMT   = 2'd1;
    localparam logic [1:0] REG_VAR   = 2'd2;
    localparam logic [1:0] REG_ALPHA = 2'd3;

    // settings shared by all lanes
    typedef struct packed {
        logic [3:0] mode;
        logic       variant;
        logic [8:0] alpha;
    } lane_cfg_t;

    // per-item control carried down the pipe
    typedef struct packed {
        logic        pass;
        logic        written;
        logic [1:0]  fmt;
        logic [15:0] dn;
    } item_ctl_t;
endpackage

// ----- rtl/core/pab_stream_if.sv -----
`timescale 1ns / 1ps
interface pab_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/pab_lane.sv -----
`timescale 1ns / 1ps
// One channel core, two register stages: products and upper quotient bits,
// then scale divide, lower quotient bits and clamp.
// Division by the scale s = 2^k-1 uses q = (x + (x>>k) + 1) >> k, exact for x < s*s+s.
// Operand divide: b = 0 gives 0, a >= b clamps to s, so only a < b needs a quotient,
// which fits ChanW bits; its restoring steps are split evenly over the two stages.
module pab_lane
    import pab_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  lane_cfg_t        cfg,
    input  logic [3:0]       k,
    input  logic [ChanW-1:0] d,
    input  logic [ChanW-1:0] o,
    output logic [ChanW-1:0] res
);
    // quotient bits resolved per stage
    localparam int DivW = ChanW / 2;

    // k is 1, 5, 6 or 8
    logic [ChanW-1:0]   s;
    logic [ChanW-1:0]   a, b, dmin, dmax;
    logic [8:0]         alpha_sat;
    logic [15:0]        prod_next, prod_reg;
    logic [16:0]        blend_next;
    logic [ChanW-1:0]   simple_next, simple_reg, b_reg, s_reg;
    logic [3:0]         k_reg;
    logic [ChanW:0]     sum;
    logic [2*ChanW-1:0] xd;
    logic [ChanW:0]     rem_a;
    logic [ChanW-1:0]   rem_a_next, rem_a_reg;
    logic [DivW-1:0]    qa_next, qa_reg, xlo_reg;
    logic               sat_next, sat_reg;

    assign s         = ChanW'((9'd1 << k) - 9'd1);
    assign a         = cfg.variant ? o : d;
    assign b         = cfg.variant ? d : o;
    assign dmin      = (d < o) ? d : o;
    assign dmax      = (d < o) ? o : d;
    assign alpha_sat = cfg.alpha[8] ? 9'd256 : cfg.alpha;
    assign sum       = {1'b0, d} + {1'b0, o};
    assign blend_next = 17'(d * alpha_sat) + 17'(o * (9'd256 - alpha_sat));
    assign xd        = ((2*ChanW)'(a) << k) - (2*ChanW)'(a);
    assign sat_next  = (a >= b);

    // stage 1: one product per lane for multiply, else the simple result
    always_comb
    begin
        prod_next   = '0;
        simple_next = '0;
        unique case (cfg.mode)
            OP_NEG:   simple_next = s - d;
            OP_COPY:  simple_next = o;
            OP_ADD:   simple_next = (sum > {1'b0, s}) ? s : sum[ChanW-1:0];
            OP_SUB:   simple_next = (a > b) ? a - b : '0;
            OP_MUL:   prod_next = cfg.variant ? (s - d) * (s - o) : d * o;
            OP_DIV:   prod_next = '0;
            OP_MIN:   simple_next = dmin;
            OP_MAX:   simple_next = dmax;
            OP_DIFF:  simple_next = dmax - dmin;
            OP_BLEND: simple_next = blend_next[15:8];
            default:  simple_next = '0;
        endcase
    end

    // stage 1: upper quotient bits of a*s / b
    always_comb
    begin
        qa_next = '0;
        rem_a   = {1'b0, xd[2*ChanW-1:ChanW]};
        for (int i = DivW - 1; i >= 0; i--)
        begin
            rem_a = {rem_a[ChanW-1:0], xd[DivW + i]};
            if (rem_a >= {1'b0, b})
            begin
                rem_a      = rem_a - {1'b0, b};
                qa_next[i] = 1'b1;
            end
        end
        rem_a_next = rem_a[ChanW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            simple_reg <= simple_next;
            b_reg      <= b;
            s_reg      <= s;
            k_reg      <= k;
            rem_a_reg  <= rem_a_next;
            qa_reg     <= qa_next;
            xlo_reg    <= xd[DivW-1:0];
            sat_reg    <= sat_next;
        end
    end

    // stage 2: divide by the scale, finish the operand divide, or pass the simple result
    logic [16:0]      x1, q_s;
    logic [15:0]      xc;
    logic [ChanW:0]   rem_b;
    logic [DivW-1:0]  qb;
    logic [ChanW-1:0] res_next, res_reg;
    always_comb
    begin
        xc  = prod_reg + (cfg.variant ? 16'(s_reg) - 16'd1 : 16'd0);
        x1  = {1'b0, xc} + 17'(xc >> k_reg) + 17'd1;
        q_s = x1 >> k_reg;
        // lower quotient bits
        qb    = '0;
        rem_b = {1'b0, rem_a_reg};
        for (int i = DivW - 1; i >= 0; i--)
        begin
            rem_b = {rem_b[ChanW-1:0], xlo_reg[i]};
            if (rem_b >= {1'b0, b_reg})
            begin
                rem_b = rem_b - {1'b0, b_reg};
                qb[i] = 1'b1;
            end
        end
        unique case (cfg.mode)
            OP_MUL:  res_next = cfg.variant ? s_reg - q_s[ChanW-1:0] : q_s[ChanW-1:0];
            OP_DIV:  res_next = (b_reg == '0) ? '0 :
                                sat_reg ? s_reg : {qa_reg, qb};
            default: res_next = simple_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;
endmodule

// ----- rtl/core/pab_merge.sv -----
`timescale 1ns / 1ps
// Packs the lane results into the configured pixel format, or passes dn through for pass items.
module pab_merge
    import pab_pkg::*;
(
    input  item_ctl_t        ctl,
    input  logic [ChanW-1:0] r,
    input  logic [ChanW-1:0] g,
    input  logic [ChanW-1:0] b,
    output logic [15:0]      pixel,
    output logic             written
);
    always_comb
    begin
        written = ctl.written;
        if (ctl.pass)
            pixel = ctl.dn;
        else
        begin
            unique case (ctl.fmt)
                FMT_BIN:  pixel = {15'd0, g[0]};
                FMT_GRAY: pixel = {8'd0, g};
                default:  pixel = {r[4:0], g[5:0], b[4:0]};
            endcase
        end
    end
endmodule

// ----- rtl/core/pixel_arith_blend_unit.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_ch    in   dest_pixel[15:0], other_pixel[15:0], mask_bit
// out_ch   out  result_pixel[15:0], pixel_written
// apb      in   operation_mode, pixel_format, variant_flag, blend_alpha
// One pixel per clock while the output is not stalled; two lane stages, then the output register.
// Three lanes (R, G/gray/binary, B) run in parallel; each splits its operand divide
// over its two stages.
// rst_n clears the valids and loads the register reset values asynchronously.
// A stalled output holds the whole pipe, bubbles included; input is ready whenever
// the output register is empty or being taken.
module pixel_arith_blend_unit
    import pab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pab_stream_if.sink   in_ch,
    pab_stream_if.source out_ch
);
    logic [3:0] mode_reg;
    logic [1:0] fmt_reg;
    logic       var_reg;
    logic [8:0] alpha_reg;
    logic       wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= OP_NEG;
            fmt_reg   <= FMT_GRAY;
            var_reg   <= 1'b0;
            alpha_reg <= 9'd128;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[3:0];
                REG_FMT:   fmt_reg   <= pwdata[1:0];
                REG_VAR:   var_reg   <= pwdata[0];
                REG_ALPHA: alpha_reg <= pwdata[8:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE: prdata = {28'd0, mode_reg};
            REG_FMT:  prdata = {30'd0, fmt_reg};
            REG_VAR:  prdata = {31'd0, var_reg};
            default:  prdata = {23'd0, alpha_reg};
        endcase
    end

    // pipeline control
    logic v1_reg, v2_reg, vo_reg, adv;
    assign adv          = !vo_reg || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            vo_reg <= v2_reg;
        end
    end

    // input decode
    logic [15:0] d, o;
    logic        m;
    item_ctl_t   ctl_next, ctl1_reg, ctl2_reg;
    lane_cfg_t   cfg;
    assign {d, o, m} = in_ch.data;
    assign cfg = '{mode: mode_reg, variant: var_reg, alpha: alpha_reg};

    always_comb
    begin
        ctl_next.fmt = fmt_reg;
        unique case (fmt_reg)
            FMT_BIN:  ctl_next.dn = {15'd0, d[0]};
            FMT_GRAY: ctl_next.dn = {8'd0, d[7:0]};
            default:  ctl_next.dn = d;
        endcase
        ctl_next.pass = (fmt_reg == FMT_RSVD) || (mode_reg > OP_BLEND)
                        || (mode_reg != OP_NEG && !m);
        ctl_next.written = !ctl_next.pass;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl1_reg <= ctl_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    // lane operands
    logic [ChanW-1:0] dr, dg, db, or_, og, ob, rr, rg, rb;
    logic [3:0]       kg;
    always_comb
    begin
        dr = {3'd0, d[15:11]};
        or_ = {3'd0, o[15:11]};
        db = {3'd0, d[4:0]};
        ob = {3'd0, o[4:0]};
        unique case (fmt_reg)
            FMT_BIN:  begin dg = {7'd0, d[0]}; og = {7'd0, o[0]}; kg = 4'd1; end
            FMT_GRAY: begin dg = d[7:0];       og = o[7:0];       kg = 4'd8; end
            default:  begin dg = {2'd0, d[10:5]}; og = {2'd0, o[10:5]}; kg = 4'd6; end
        endcase
    end

    pab_lane u_lane_r (.clk(clk), .en(adv), .cfg(cfg), .k(4'd5), .d(dr), .o(or_), .res(rr));
    pab_lane u_lane_g (.clk(clk), .en(adv), .cfg(cfg), .k(kg), .d(dg), .o(og), .res(rg));
    pab_lane u_lane_b (.clk(clk), .en(adv), .cfg(cfg), .k(4'd5), .d(db), .o(ob), .res(rb));

    logic [15:0] pix;
    logic        wrt;
    pab_merge u_merge (.ctl(ctl2_reg), .r(rr), .g(rg), .b(rb), .pixel(pix), .written(wrt));

    // output register
    logic [16:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= {pix, wrt};
    end
    assign out_ch.data = out_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_reg))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready && v2_reg |=> vo_reg)
        else $error("item lost in pipe");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import pab_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pab_stream_if #(.W(33)) in_ch ();
    pab_stream_if #(.W(17)) out_ch ();

    pixel_arith_blend_unit uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    typedef struct packed {
        logic [15:0] pix;
        logic        written;
    } pix_result_t;

    // local copy of the register settings
    logic [3:0] cur_mode;
    logic [1:0] cur_fmt;
    logic       cur_var;
    logic [8:0] cur_alpha;

    pix_result_t expected_pix_q[$];
    int          err_count;
    int          idle_cycles;
    bit          idling_on;
    bit          hold_sink;
    int          sink_hold_len;
    bit          timed_out;

    localparam int WATCHDOG_LIMIT = 20000;

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // one channel of the pixel operation at scale s
    function automatic logic [7:0] chan_calc(logic [7:0] d8, logic [7:0] o8, logic [7:0] s8);
        int unsigned d;
        int unsigned o;
        int unsigned s;
        int unsigned a;
        int unsigned b;
        int unsigned x;
        int unsigned w;
        int unsigned r;
        d = d8;
        o = o8;
        s = s8;
        case (cur_mode)
            OP_NEG:  r = s - d;
            OP_COPY: r = o;
            OP_ADD:  r = (d + o > s) ? s : d + o;
            OP_SUB:
            begin
                a = cur_var ? o : d;
                b = cur_var ? d : o;
                r = (a > b) ? a - b : 0;
            end
            OP_MUL:
            begin
                if (cur_var)
                begin
                    x = (s - d) * (s - o);
                    r = s - (x + s - 1) / s;
                end
                else
                    r = (d * o) / s;
            end
            OP_DIV:
            begin
                a = cur_var ? o : d;
                b = cur_var ? d : o;
                if (b == 0)
                    r = 0;
                else
                begin
                    x = (a * s) / b;
                    r = (x > s) ? s : x;
                end
            end
            OP_MIN:  r = (d < o) ? d : o;
            OP_MAX:  r = (d > o) ? d : o;
            OP_DIFF: r = (d > o) ? d - o : o - d;
            default:
            begin
                w = (cur_alpha > 256) ? 256 : cur_alpha;
                r = (d * w + o * (256 - w)) >> 8;
            end
        endcase
        return r[7:0];
    endfunction

    // expected output pixel for one input transfer
    function automatic pix_result_t blend_pixel(logic [15:0] d, logic [15:0] o, logic m);
        pix_result_t res;
        logic [15:0] dn;
        logic [7:0]  rc;
        logic [7:0]  gc;
        logic [7:0]  bc;
        if (cur_fmt == FMT_BIN)
            dn = {15'd0, d[0]};
        else if (cur_fmt == FMT_GRAY)
            dn = {8'd0, d[7:0]};
        else
            dn = d;
        res.pix = dn;
        res.written = 1'b0;
        if (cur_fmt == FMT_RSVD || cur_mode > OP_BLEND)
            return res;
        if (cur_mode != OP_NEG && !m)
            return res;
        res.written = 1'b1;
        if (cur_fmt == FMT_BIN)
        begin
            rc = chan_calc({7'd0, d[0]}, {7'd0, o[0]}, 8'd1);
            res.pix = {15'd0, rc[0]};
        end
        else if (cur_fmt == FMT_GRAY)
        begin
            rc = chan_calc(d[7:0], o[7:0], 8'd255);
            res.pix = {8'd0, rc};
        end
        else
        begin
            rc = chan_calc({3'd0, d[15:11]}, {3'd0, o[15:11]}, 8'd31);
            gc = chan_calc({2'd0, d[10:5]}, {2'd0, o[10:5]}, 8'd63);
            bc = chan_calc({3'd0, d[4:0]}, {3'd0, o[4:0]}, 8'd31);
            res.pix = {rc[4:0], gc[5:0], bc[4:0]};
        end
        return res;
    endfunction

    // APB register write, setup then access, then the bus goes idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE: cur_mode  = val[3:0];
            REG_FMT:  cur_fmt   = val[1:0];
            REG_VAR:  cur_var   = val[0];
            default:  cur_alpha = val[8:0];
        endcase
    endtask

    // stop offering and let the pipe drain before touching registers
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_pix_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] mode, logic [1:0] fmt, logic v, logic [8:0] alpha);
        wait_drained();
        write_reg(REG_MODE, {28'd0, mode});
        write_reg(REG_FMT, {30'd0, fmt});
        write_reg(REG_VAR, {31'd0, v});
        write_reg(REG_ALPHA, {23'd0, alpha});
    endtask

    // send one pixel; the prediction is made at the transfer edge
    task automatic send_pixel(logic [15:0] d, logic [15:0] o, logic m);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {d, o, m};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_pix_q.push_back(blend_pixel(d, o, m));
    endtask

    // sender keeps valid high between pixels unless idling inserts a gap
    task automatic send_burst(int n);
        for (int i = 0; i < n; i++)
            send_pixel(16'($urandom), 16'($urandom), $urandom_range(0, 4) != 0);
    endtask

    // receiver side: random stalls, or a long forced hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= 0;
        end
        else if (hold_sink && sink_hold_len > 0)
        begin
            out_ch.ready  <= 1'b0;
            sink_hold_len <= sink_hold_len - 1;
        end
        else if (idle_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= idle_cycles - 1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= $urandom_range(0, 7);
        end
        else
            out_ch.ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        pix_result_t got;
        pix_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_pix_q.size() == 0)
            begin
                $error("unexpected result transfer pixel=%h", got.pix);
                err_count++;
            end
            else
            begin
                want = expected_pix_q.pop_front();
                if (got.pix !== want.pix)
                begin
                    $error("result_pixel expected %h actual %h", want.pix, got.pix);
                    err_count++;
                end
                if (got.written !== want.written)
                begin
                    $error("pixel_written expected %b actual %b", want.written, got.written);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        int quiet;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("DONE: errors detected");
            $finish;
        end
    end

    // directed pixels for every mode in grayscale, corner pixels in 565 divide, binary blend
    task automatic test_directed();
        logic [15:0] corners[4];
        corners = '{16'h0000, 16'hFFFF, 16'h8410, 16'h07E0};
        for (int m = OP_NEG; m <= OP_BLEND; m++)
        begin
            set_config(m[3:0], FMT_GRAY, 1'b0, 9'd128);
            send_pixel(16'h00FF, 16'h0000, 1'b1);
            send_pixel(16'h0000, 16'h00FF, 1'b0);
        end
        set_config(OP_DIV, FMT_565, 1'b1, 9'd256);
        for (int i = 0; i < 4; i++)
            send_pixel(corners[i], corners[3 - i], 1'b1);
        set_config(OP_BLEND, FMT_BIN, 1'b0, 9'd511);
        send_pixel(16'hFFFF, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 1'b1);
    endtask

    // unused mode and unused format pass through
    task automatic test_unused_codes();
        set_config(4'd15, FMT_GRAY, 1'b0, 9'd0);
        send_burst(3);
        set_config(OP_ADD, FMT_RSVD, 1'b0, 9'd0);
        send_burst(3);
    endtask

    // random settings and pixels, including unused codes and alpha extremes
    task automatic test_random();
        for (int k = 0; k < 30; k++)
            begin
                set_config(4'($urandom_range(0, 15) < 13 ? $urandom_range(0, 9)
                                                         : $urandom_range(10, 15)),
                           $urandom_range(0, 9) == 0 ? FMT_RSVD : 2'($urandom_range(0, 2)),
                           1'($urandom_range(0, 1)),
                           $urandom_range(0, 3) == 0 ? 9'(($urandom_range(0, 1)) * 511)
                                                     : 9'($urandom_range(0, 256)));
                send_burst(12);
            end
    endtask

    // receiver stalls long so the pipe fills, then sender waits for drain
    task automatic test_backpressure();
        set_config(OP_MUL, FMT_565, 1'b1, 9'd64);
        sink_hold_len = 60;
        hold_sink = 1'b1;
        send_burst(20);
        hold_sink = 1'b0;
        wait_drained();
        send_burst(10);
    endtask

    // last stretch with no idling on either side
    task automatic test_streaming();
        idling_on = 1'b0;
        set_config(OP_SUB, FMT_GRAY, 1'b1, 9'd200);
        send_burst(40);
    endtask

    initial
    begin
        err_count     = 0;
        idling_on     = 1'b1;
        hold_sink     = 1'b0;
        sink_hold_len = 0;
        timed_out     = 1'b0;
        cur_mode      = OP_NEG;
        cur_fmt       = FMT_GRAY;
        cur_var       = 1'b0;
        cur_alpha     = 9'd128;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: negate on grayscale
        send_pixel(16'h12A5, 16'h0000, 1'b0);
        test_directed();
        test_unused_codes();
        test_backpressure();
        test_random();
        test_streaming();

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
